// File: sv/xbe_pkg.sv
// ----------------------------------------------------------------------------
// xbe_pkg
// Types, character codes and helper functions shared by the XML byte escaper.
// ----------------------------------------------------------------------------
package xbe_pkg;

    typedef enum logic [2:0] {
        KIND_PASS = 3'd0,
        KIND_AMP  = 3'd1,
        KIND_LT   = 3'd2,
        KIND_GT   = 3'd3,
        KIND_QUOT = 3'd4,
        KIND_APOS = 3'd5,
        KIND_HEX  = 3'd6
    } esc_kind_t;

    typedef logic [2:0] esc_len_t;
    typedef logic [2:0] esc_idx_t;

    typedef struct packed {
        logic [7:0] data;
        esc_kind_t  kind;
        esc_len_t   len;
        logic       eob;
    } esc_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_QUOT = 8'h22;
    localparam logic [7:0] CH_APOS = 8'h27;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_HASH = 8'h23;

    localparam esc_len_t LEN_PASS  = 3'd1;
    localparam esc_len_t LEN_SHORT = 3'd4;
    localparam esc_len_t LEN_MID   = 3'd5;
    localparam esc_len_t LEN_LONG  = 3'd6;

    function automatic logic [7:0] hex_digit(logic [3:0] nib);
        logic [7:0] res;
        if (nib < 4'd10)
        begin
            res = {4'h3, nib};
        end
        else
        begin
            res = {4'h0, nib} + 8'h37;
        end
        return res;
    endfunction

    function automatic logic [7:0] esc_char(esc_entry_t e, esc_idx_t idx);
        logic [7:0] c;
        c = CH_SEMI;
        case (e.kind)
            KIND_PASS: c = e.data;
            KIND_AMP:
            begin
                case (idx)
                    3'd0: c = CH_AMP;
                    3'd1: c = "a";
                    3'd2: c = "m";
                    3'd3: c = "p";
                    default: c = CH_SEMI;
                endcase
            end
            KIND_LT, KIND_GT:
            begin
                case (idx)
                    3'd0: c = CH_AMP;
                    3'd1: c = (e.kind == KIND_LT) ? "l" : "g";
                    3'd2: c = "t";
                    default: c = CH_SEMI;
                endcase
            end
            KIND_QUOT:
            begin
                case (idx)
                    3'd0: c = CH_AMP;
                    3'd1: c = "q";
                    3'd2: c = "u";
                    3'd3: c = "o";
                    3'd4: c = "t";
                    default: c = CH_SEMI;
                endcase
            end
            KIND_APOS:
            begin
                case (idx)
                    3'd0: c = CH_AMP;
                    3'd1: c = "a";
                    3'd2: c = "p";
                    3'd3: c = "o";
                    3'd4: c = "s";
                    default: c = CH_SEMI;
                endcase
            end
            KIND_HEX:
            begin
                case (idx)
                    3'd0: c = CH_AMP;
                    3'd1: c = CH_HASH;
                    3'd2: c = "x";
                    3'd3: c = (e.len == LEN_LONG) ? hex_digit(e.data[7:4])
                                                  : hex_digit(e.data[3:0]);
                    3'd4: c = (e.len == LEN_LONG) ? hex_digit(e.data[3:0]) : CH_SEMI;
                    default: c = CH_SEMI;
                endcase
            end
            default: c = CH_SEMI;
        endcase
        return c;
    endfunction

endpackage

// File: sv/xbe_front.sv
// ----------------------------------------------------------------------------
// xbe_front
// Accepts raw bytes, classifies them and pushes one entry per byte into the
// queue.
// ----------------------------------------------------------------------------
module xbe_front
(
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            byte_in,
    input  logic                  end_of_buffer,
    input  xbe_pkg::queue_status_t q_status,
    output logic                  push,
    output xbe_pkg::esc_entry_t   entry
);
    import xbe_pkg::*;

    esc_kind_t kind;
    esc_len_t  len;

    always_comb
    begin
        kind = KIND_PASS;
        len  = LEN_PASS;
        case (byte_in) inside
            CH_AMP:
            begin
                kind = KIND_AMP;
                len  = LEN_MID;
            end
            CH_LT:
            begin
                kind = KIND_LT;
                len  = LEN_SHORT;
            end
            CH_GT:
            begin
                kind = KIND_GT;
                len  = LEN_SHORT;
            end
            CH_QUOT:
            begin
                kind = KIND_QUOT;
                len  = LEN_LONG;
            end
            CH_APOS:
            begin
                kind = KIND_APOS;
                len  = LEN_LONG;
            end
            [8'h00:8'h0F]:
            begin
                kind = KIND_HEX;
                len  = LEN_MID;
            end
            [8'h10:8'h1F], [8'h7F:8'hFF]:
            begin
                kind = KIND_HEX;
                len  = LEN_LONG;
            end
            default:
            begin
                kind = KIND_PASS;
                len  = LEN_PASS;
            end
        endcase
    end

    assign in_stall   = q_status.full;
    assign push       = in_valid && !q_status.full;
    assign entry.data = byte_in;
    assign entry.kind = kind;
    assign entry.len  = len;
    assign entry.eob  = end_of_buffer;

endmodule

// File: sv/xbe_queue.sv
// ----------------------------------------------------------------------------
// xbe_queue
// Short register queue of classified entries between front and back.
// ----------------------------------------------------------------------------
module xbe_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  xbe_pkg::esc_entry_t    wr_entry,
    input  logic                   pop,
    output xbe_pkg::esc_entry_t    rd_entry,
    output xbe_pkg::queue_status_t status
);
    import xbe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    esc_entry_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    assign rd_entry     = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

// File: sv/xbe_back.sv
// ----------------------------------------------------------------------------
// xbe_back
// Expands the head entry into its escaped characters, one per cycle unless
// the output stalls or the queue is empty, into an output register.
// ----------------------------------------------------------------------------
module xbe_back
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  xbe_pkg::esc_entry_t    head,
    input  xbe_pkg::queue_status_t q_status,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [7:0]             out_byte,
    output logic                   last_of_run,
    output logic                   end_of_buffer_out
);
    import xbe_pkg::*;

    esc_idx_t   idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       last_reg, eob_reg;
    logic       out_free;
    logic       emit;
    logic       is_last;

    assign out_free = !valid_reg || !out_stall;
    assign emit     = out_free && !q_status.empty;
    assign is_last  = (idx_reg == head.len - 3'd1);
    assign pop      = emit && is_last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (emit)
        begin
            valid_next = 1'b1;
            idx_next   = is_last ? '0 : idx_reg + 3'd1;
        end
        else if (out_free)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            byte_reg <= esc_char(head, idx_reg);
            last_reg <= is_last;
            eob_reg  <= is_last && head.eob;
        end
    end

    assign out_valid         = valid_reg;
    assign out_byte          = byte_reg;
    assign last_of_run       = last_reg;
    assign end_of_buffer_out = eob_reg;

endmodule

// File: sv/xml_byte_escaper.sv
// ----------------------------------------------------------------------------
// xml_byte_escaper
// Escapes a byte stream for XML, one output character per transaction.
// ----------------------------------------------------------------------------
//  channel  handshake            fields
//  in       in_valid/in_stall    byte_in, end_of_buffer
//  out      out_valid/out_stall  out_byte, last_of_run, end_of_buffer_out
//
//  Plain bytes flow at one per cycle while out_stall is low; an escaped byte
//  occupies the back end until every character of its form (4 to 6) is sent.
//  The first result passes through the queue and then the output register.
//  in_stall rises only when the queue of QUEUE_DEPTH entries is full.
//  Reset empties the queue and clears the output valid flag; no clearing pass.
// ----------------------------------------------------------------------------
module xml_byte_escaper
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] byte_in,
    input  logic       end_of_buffer,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       last_of_run,
    output logic       end_of_buffer_out
);
    import xbe_pkg::*;

    queue_status_t q_status;
    esc_entry_t    wr_entry;
    esc_entry_t    head;
    logic          push;
    logic          pop;

    xbe_front u_front
    (
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .byte_in       (byte_in),
        .end_of_buffer (end_of_buffer),
        .q_status      (q_status),
        .push          (push),
        .entry         (wr_entry)
    );

    xbe_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .pop      (pop),
        .rd_entry (head),
        .status   (q_status)
    );

    xbe_back u_back
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .head              (head),
        .q_status          (q_status),
        .pop               (pop),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .out_byte          (out_byte),
        .last_of_run       (last_of_run),
        .end_of_buffer_out (end_of_buffer_out)
    );

endmodule

// File: sv/xbe_checker.sv
// ----------------------------------------------------------------------------
// xbe_checker
// Port-level checks on the escaper's output stream.
// ----------------------------------------------------------------------------
module xbe_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       last_of_run,
    input logic       end_of_buffer_out
);
    import xbe_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out_valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=>
            $stable(out_byte) && $stable(last_of_run) && $stable(end_of_buffer_out))
        else $error("output payload changed while stalled");

    a_eob_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_buffer_out |-> last_of_run)
        else $error("end of buffer flagged on a non-final character");

    a_semi_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> out_byte != CH_SEMI)
        else $error("semicolon emitted inside an escape run");

    a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run && $past(out_valid && !out_stall && last_of_run)
            |-> out_byte == CH_AMP)
        else $error("escape run does not start with an ampersand");

endmodule

bind xml_byte_escaper xbe_checker u_xbe_checker (.*);

// File: dv/tb_xml_byte_escaper.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_xml_byte_escaper
// Self-checking bench for the XML byte escaper. A queue-fed driver sends raw
// bytes, each accepted transaction is expanded into its expected escaped
// characters, and a monitor checks every output transaction against them.
// Four idle/stall mixes run back to back after a directed set of edge bytes.
// ----------------------------------------------------------------------------
module tb_xml_byte_escaper;

    import xbe_pkg::*;

    localparam int IDLE_LIMIT   = 4000;
    localparam int RANDOM_BYTES = 220;
    localparam int TAIL_CYCLES  = 12;

    typedef struct {
        logic [7:0] data;
        logic       eob;
    } raw_byte_t;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        logic       eob;
    } esc_char_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] byte_in;
    logic       end_of_buffer;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       end_of_buffer_out;

    raw_byte_t raw_bytes_q[$];
    esc_char_t escaped_chars_q[$];

    logic in_taken;
    int   src_idle_pct;
    int   snk_stall_pct;
    int   idle_cycles;
    int   mismatches;
    int   bytes_taken;
    int   bytes_escaped;
    int   chars_checked;

    xml_byte_escaper DUT
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .byte_in           (byte_in),
        .end_of_buffer     (end_of_buffer),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .out_byte          (out_byte),
        .last_of_run       (last_of_run),
        .end_of_buffer_out (end_of_buffer_out)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    function automatic string hex_nibble(logic [3:0] nib);
        string digits;
        digits = "0123456789ABCDEF";
        return digits.substr(nib, nib);
    endfunction

    // Expected character sequence for one raw byte
    function automatic void push_escaped_form(logic [7:0] b, logic eob);
        string form;
        int    n;
        esc_char_t c;
        case (b)
            CH_AMP:  form = "&amp;";
            CH_LT:   form = "&lt;";
            CH_GT:   form = "&gt;";
            CH_QUOT: form = "&quot;";
            CH_APOS: form = "&apos;";
            default:
            begin
                if (b < 8'd32 || b >= 8'd127)
                begin
                    form = "&#x";
                    if (b >= 8'd16)
                    begin
                        form = {form, hex_nibble(b[7:4])};
                    end
                    form = {form, hex_nibble(b[3:0]), ";"};
                end
                else
                begin
                    form = $sformatf("%c", b);
                end
            end
        endcase
        n = form.len();
        if (n > 1)
        begin
            bytes_escaped++;
        end
        for (int i = 0; i < n; i++)
        begin
            c.ch   = form[i];
            c.last = (i == n - 1);
            c.eob  = (i == n - 1) ? eob : 1'b0;
            escaped_chars_q.push_back(c);
        end
    endfunction

    function automatic logic [7:0] rand_raw_byte();
        logic [7:0] b;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: b = 8'($urandom_range(32, 126));
            4, 5:
            begin
                case ($urandom_range(0, 4))
                    0: b = CH_AMP;
                    1: b = CH_LT;
                    2: b = CH_GT;
                    3: b = CH_QUOT;
                    default: b = CH_APOS;
                endcase
            end
            6, 7: b = 8'($urandom_range(0, 31));
            default: b = 8'($urandom_range(0, 255));
        endcase
        return b;
    endfunction

    function automatic void queue_raw_byte(logic [7:0] b, logic eob);
        raw_byte_t r;
        r.data = b;
        r.eob  = eob;
        raw_bytes_q.push_back(r);
    endfunction

    // Driver: presents the next pending byte once the previous one is taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (raw_bytes_q.size() > 0 && $urandom_range(0, 99) >= src_idle_pct)
                begin
                    byte_in       <= raw_bytes_q[0].data;
                    end_of_buffer <= raw_bytes_q[0].eob;
                    in_valid      <= 1'b1;
                    void'(raw_bytes_q.pop_front());
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= ($urandom_range(0, 99) < snk_stall_pct);
        end
    end

    // Monitor: records input transactions and checks output transactions
    always @(posedge clk)
    begin
        esc_char_t e;
        if (rst_n)
        begin
            in_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                push_escaped_form(byte_in, end_of_buffer);
                bytes_taken++;
            end
            if (out_valid && !out_stall)
            begin
                chars_checked++;
                if (escaped_chars_q.size() == 0)
                begin
                    $error("unexpected output transaction: out_byte=%02h", out_byte);
                    mismatches++;
                end
                else
                begin
                    e = escaped_chars_q.pop_front();
                    if (out_byte !== e.ch)
                    begin
                        $error("out_byte: expected %02h, got %02h", e.ch, out_byte);
                        mismatches++;
                    end
                    if (last_of_run !== e.last)
                    begin
                        $error("last_of_run: expected %0b, got %0b", e.last, last_of_run);
                        mismatches++;
                    end
                    if (end_of_buffer_out !== e.eob)
                    begin
                        $error("end_of_buffer_out: expected %0b, got %0b",
                               e.eob, end_of_buffer_out);
                        mismatches++;
                    end
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT)
                begin
                    $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
                    $display("** xml_byte_escaper: FAILED **");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        logic [7:0] edge_bytes[$];
        int idle_mix[4];
        int stall_mix[4];

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        byte_in       = 8'h00;
        end_of_buffer = 1'b0;
        out_stall     = 1'b0;
        in_taken      = 1'b0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        idle_cycles   = 0;
        mismatches    = 0;
        bytes_taken   = 0;
        bytes_escaped = 0;
        chars_checked = 0;
        idle_mix      = '{0, 63, 0, 13};
        stall_mix     = '{0, 0, 63, 13};

        edge_bytes = '{8'h00, 8'h01, 8'h09, 8'h0A, 8'h0D, 8'h0F, 8'h10, 8'h1F,
                       8'h20, 8'h21, CH_QUOT, CH_AMP, CH_APOS, CH_LT, CH_GT,
                       8'h41, 8'h7E, 8'h7F, 8'h80, 8'hA5, 8'hF0, 8'hFF};
        foreach (edge_bytes[i])
        begin
            queue_raw_byte(edge_bytes[i], (i % 3 == 2) || (i == edge_bytes.size() - 1));
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int p = 0; p < 4; p++)
        begin
            src_idle_pct  = idle_mix[p];
            snk_stall_pct = stall_mix[p];
            for (int i = 0; i < RANDOM_BYTES / 4; i++)
            begin
                queue_raw_byte(rand_raw_byte(), ($urandom_range(0, 7) == 0));
            end
            do
            begin
                @(posedge clk);
            end
            while (raw_bytes_q.size() != 0 || in_valid || escaped_chars_q.size() != 0);
        end

        snk_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge clk);
        if (escaped_chars_q.size() != 0)
        begin
            $error("%0d expected characters never arrived", escaped_chars_q.size());
            mismatches++;
        end

        $display("Sent %0d raw bytes (%0d needing escapes), checked %0d output characters,",
                 bytes_taken, bytes_escaped, chars_checked);
        $display("across free-running, sender-idle, receiver-stall and mixed phases.");
        if (mismatches == 0)
        begin
            $display("** xml_byte_escaper: PASSED **");
        end
        else
        begin
            $display("** xml_byte_escaper: FAILED **");
        end
        $finish;
    end

endmodule
